// File: hdl/wdsb_pkg.sv
// package for the wheel drive slew and start boost unit
// shared types, register indexes and drive constants; no dependencies
package wdsb_pkg;

  localparam int DriveFullScale = 1000;
  localparam int DriveW         = 11;
  localparam int SpeedW         = 16;
  localparam int CfgIdxW        = 3;
  localparam int CfgDataW       = 16;
  localparam int InDataW        = 6 * SpeedW;
  localparam int OutDataW       = 32;

  localparam logic signed [DriveW-1:0] DriveMax = DriveW'(DriveFullScale);
  localparam logic signed [DriveW-1:0] DriveMin = -DriveMax;

  typedef enum logic [CfgIdxW-1:0] {
    CfgSpeedLimit = 3'd0,
    CfgDeadband   = 3'd1,
    CfgMoving     = 3'd2,
    CfgBoostLevel = 3'd3,
    CfgSlewStep   = 3'd4,
    CfgBoostTicks = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [14:0] speed_limit;
    logic [14:0] deadband;
    logic [14:0] moving;
    logic [9:0]  boost_level;
    logic [9:0]  slew_step;
    logic [15:0] boost_ticks;
  } cfg_t;

  // per wheel result handed from a lane to the merge stage
  typedef struct packed {
    logic signed [DriveW-1:0] drive;
    logic                     boosting;
    logic                     clamp_hit;
  } lane_res_t;

endpackage

// File: hdl/wdsb_lane.sv
// one wheel lane: target clamp, deadband, boost counter, boost raise and slew limit
// holds the wheel's state registers; depends on wdsb_pkg
module wdsb_lane (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  wdsb_pkg::cfg_t                       cfg_i,
  input  logic                                 step_i,
  input  logic signed [wdsb_pkg::SpeedW-1:0]   target_i,
  input  logic signed [wdsb_pkg::SpeedW-1:0]   actual_i,
  input  logic signed [wdsb_pkg::SpeedW-1:0]   request_i,
  output wdsb_pkg::lane_res_t                  res_o
);
  import wdsb_pkg::*;

  logic signed [DriveW-1:0] last_drive_q, last_drive_d;
  logic signed [SpeedW-1:0] last_target_q, last_target_d;
  logic [15:0]              boost_q, boost_d;

  logic signed [16:0] lim17, nlim17, tgt17, act17, act_mag, req17, db17, ndb17, prev17;
  logic signed [SpeedW-1:0] tgt_c;
  logic signed [11:0] drv, lvl, step, last12, delta;
  logic hit, active, prev_active, reversal, moving, boosting;
  logic [15:0] cnt;

  always_comb begin
    lim17  = $signed({2'b00, cfg_i.speed_limit});
    nlim17 = -lim17;
    tgt17  = {target_i[SpeedW-1], target_i};
    hit    = 1'b0;
    if (tgt17 > lim17) begin
      tgt_c = lim17[SpeedW-1:0];
      hit   = 1'b1;
    end else if (tgt17 < nlim17) begin
      tgt_c = nlim17[SpeedW-1:0];
      hit   = 1'b1;
    end else begin
      tgt_c = target_i;
    end

    // deadband judged with the current register for both old and new target
    db17        = $signed({2'b00, cfg_i.deadband});
    ndb17       = -db17;
    tgt17       = {tgt_c[SpeedW-1], tgt_c};
    prev17      = {last_target_q[SpeedW-1], last_target_q};
    active      = !((tgt17 > ndb17) && (tgt17 < db17));
    prev_active = !((prev17 > ndb17) && (prev17 < db17));
    reversal    = (last_target_q > 0 && tgt_c < 0) || (last_target_q < 0 && tgt_c > 0);

    act17   = {actual_i[SpeedW-1], actual_i};
    act_mag = (act17 < 0) ? -act17 : act17;
    moving  = act_mag > $signed({2'b00, cfg_i.moving});

    req17 = {request_i[SpeedW-1], request_i};
    if (req17 > 17'(DriveFullScale)) begin
      drv = 12'(DriveFullScale);
    end else if (req17 < -17'(DriveFullScale)) begin
      drv = -12'(DriveFullScale);
    end else begin
      drv = req17[11:0];
    end

    cnt = boost_q;
    if (!prev_active || reversal) begin
      cnt = cfg_i.boost_ticks;
    end
    if (moving) begin
      cnt = '0;
    end
    boosting = (cnt != '0);

    lvl    = $signed({2'b00, cfg_i.boost_level});
    step   = $signed({2'b00, cfg_i.slew_step});
    last12 = {last_drive_q[DriveW-1], last_drive_q};
    delta  = drv - last12;
    if (boosting) begin
      if (cfg_i.boost_level != '0) begin
        if (tgt_c >= 0 && drv < lvl) drv = lvl;
        if (tgt_c < 0 && drv > -lvl) drv = -lvl;
      end
      if (drv > 12'(DriveFullScale)) drv = 12'(DriveFullScale);
      if (drv < -12'(DriveFullScale)) drv = -12'(DriveFullScale);
    end else if (cfg_i.slew_step != '0) begin
      if (delta > step) begin
        drv = last12 + step;
      end else if (delta < -step) begin
        drv = last12 - step;
      end
    end

    last_target_d = tgt_c;
    if (active) begin
      boost_d      = boosting ? cnt - 16'd1 : cnt;
      last_drive_d = drv[DriveW-1:0];
    end else begin
      boost_d      = '0;
      last_drive_d = '0;
    end

    res_o.drive     = last_drive_d;
    res_o.boosting  = active && boosting;
    res_o.clamp_hit = hit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_drive_q  <= '0;
      last_target_q <= '0;
      boost_q       <= '0;
    end else if (step_i) begin
      last_drive_q  <= last_drive_d;
      last_target_q <= last_target_d;
      boost_q       <= boost_d;
    end
  end

`ifndef SYNTHESIS
  a_inactive_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && !active |=> last_drive_q == '0 && boost_q == '0)
    else $error("inactive target did not clear lane state");
  a_boost_needs_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.boosting |-> active && cnt != '0)
    else $error("boost flagged without active target and count");
  a_drive_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_drive_q <= DriveMax && last_drive_q >= DriveMin)
    else $error("stored drive beyond full scale");
`endif

endmodule

// File: hdl/wdsb_merge.sv
// merge stage: combines both lane results, builds the limited flag, output register
// depends on wdsb_pkg
module wdsb_merge (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  wdsb_pkg::lane_res_t               left_res_i,
  input  wdsb_pkg::lane_res_t               right_res_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [wdsb_pkg::OutDataW-1:0]     out_data_o
);
  import wdsb_pkg::*;

  logic                valid_q;
  logic [OutDataW-1:0] data_q, data_d;
  logic                limited, take;

  always_comb begin
    limited = left_res_i.clamp_hit || right_res_i.clamp_hit ||
              left_res_i.drive == DriveMax || left_res_i.drive == DriveMin ||
              right_res_i.drive == DriveMax || right_res_i.drive == DriveMin;
    data_d = OutDataW'({limited, right_res_i.boosting, left_res_i.boosting,
                        right_res_i.drive, left_res_i.drive});
  end

  // a new request enters while the held result is being taken
  assign in_ready_o  = !valid_q || out_ready_i;
  assign take        = in_valid_i && in_ready_o;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      data_q <= data_d;
    end
  end

`ifndef SYNTHESIS
  a_full_scale_limited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && ($signed(data_q[10:0]) == DriveMax || $signed(data_q[10:0]) == DriveMin)
    |-> data_q[24])
    else $error("full scale drive without limited flag");
  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !valid_q |-> in_ready_o)
    else $error("empty output stage refuses requests");
  a_take_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> valid_q)
    else $error("accepted request not held in output stage");
`endif

endmodule

// File: hdl/wheel_drive_slew_and_start_boost_unit.sv
// Wheel drive slew limiter with start boost, two wheel lanes and an output stage.
// Input stream s_axis carries one control tick: targets, measured speeds and
// controller drive requests for both wheels. Output stream m_axis carries the
// final drives, the boost flags and the combined limited flag.
// Configuration is written through cfg_we_i / cfg_idx_i / cfg_data_i, one register per
// cycle; the user must write only while no request is in flight, the block does not enforce it.
// An accepted request's result appears on m_axis in the cycle after acceptance.
// Throughput: one request per cycle unless the receiver stalls; both lanes
// are combinational, their state updated at acceptance, so back-to-back ticks see it.
// The output register lets a new request in while the held result is taken;
// when the receiver stalls with a result held, s_axis_tready_o drops.
// Reset clears the wheel state and loads the register defaults
// (limit 2000, deadband 20, moving threshold 50, others zero); no clearing pass.
// Depends on wdsb_pkg, wdsb_lane and wdsb_merge.
module wheel_drive_slew_and_start_boost_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // left_target, right_target, left_actual, right_actual, left_request, right_request
  input  logic [wdsb_pkg::InDataW-1:0]      s_axis_tdata_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // left_drive, right_drive, left_boosting, right_boosting, limited, zero fill
  output logic [wdsb_pkg::OutDataW-1:0]     m_axis_tdata_o,
  input  logic                              cfg_we_i,
  input  logic [wdsb_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [wdsb_pkg::CfgDataW-1:0]     cfg_data_i
);
  import wdsb_pkg::*;

  cfg_t      cfg_q;
  lane_res_t left_res, right_res;
  logic      step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.speed_limit <= 15'd2000;
      cfg_q.deadband    <= 15'd20;
      cfg_q.moving      <= 15'd50;
      cfg_q.boost_level <= '0;
      cfg_q.slew_step   <= '0;
      cfg_q.boost_ticks <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CfgSpeedLimit: cfg_q.speed_limit <= cfg_data_i[14:0];
        CfgDeadband:   cfg_q.deadband    <= cfg_data_i[14:0];
        CfgMoving:     cfg_q.moving      <= cfg_data_i[14:0];
        CfgBoostLevel: cfg_q.boost_level <= cfg_data_i[9:0];
        CfgSlewStep:   cfg_q.slew_step   <= cfg_data_i[9:0];
        CfgBoostTicks: cfg_q.boost_ticks <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  assign step = s_axis_tvalid_i && s_axis_tready_o;

  wdsb_lane u_left (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .step_i    (step),
    .target_i  (s_axis_tdata_i[15:0]),
    .actual_i  (s_axis_tdata_i[47:32]),
    .request_i (s_axis_tdata_i[79:64]),
    .res_o     (left_res)
  );

  wdsb_lane u_right (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .step_i    (step),
    .target_i  (s_axis_tdata_i[31:16]),
    .actual_i  (s_axis_tdata_i[63:48]),
    .request_i (s_axis_tdata_i[95:80]),
    .res_o     (right_res)
  );

  wdsb_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .left_res_i  (left_res),
    .right_res_i (right_res),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o)
  );

endmodule

// File: tb/tb_wheel_drive_slew_and_start_boost_unit.sv
`timescale 1ns / 100ps
// testbench for wheel_drive_slew_and_start_boost_unit: directed and random control ticks,
// drives predicted per wheel in the bench and checked field by field on m_axis
// depends on wdsb_pkg and the unit itself
module tb_wheel_drive_slew_and_start_boost_unit;
  import wdsb_pkg::*;

  localparam int StallLimit = 500;

  // first member sits in the highest bits, so left_target lands in tdata[15:0]
  typedef struct packed {
    logic signed [SpeedW-1:0] right_request;
    logic signed [SpeedW-1:0] left_request;
    logic signed [SpeedW-1:0] right_actual;
    logic signed [SpeedW-1:0] left_actual;
    logic signed [SpeedW-1:0] right_target;
    logic signed [SpeedW-1:0] left_target;
  } tick_t;

  typedef struct packed {
    logic [6:0]               fill;
    logic                     limited;
    logic                     right_boosting;
    logic                     left_boosting;
    logic signed [DriveW-1:0] right_drive;
    logic signed [DriveW-1:0] left_drive;
  } drive_res_t;

  typedef enum int {RxSteady, RxRandom, RxLongStall, RxCadence} rx_mode_e;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [InDataW-1:0]  s_axis_tdata_i = '0;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata_o;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = CfgSpeedLimit;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  wheel_drive_slew_and_start_boost_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // bench copy of the registers and the per wheel state
  int lim_speed = 2000;
  int band = 20;
  int move_thr = 50;
  int boost_floor = 0;
  int slew_max = 0;
  int boost_len = 0;
  int last_drive[2] = '{0, 0};
  int last_target[2] = '{0, 0};
  int boost_cnt[2] = '{0, 0};

  drive_res_t pending_drives[$];
  int errors = 0;
  int quiet_cycles = 0;

  // stimulus side
  rx_mode_e rx_mode = RxSteady;
  int rx_hold = 0;
  logic [1:0] rx_phase = '0;
  bit tx_gaps = 1'b0;
  int burst_left = 0;
  int gen_prev[2] = '{0, 0};

  function automatic bit tgt_live(input int t);
    return !((t > -band) && (t < band));
  endfunction

  function automatic int wheel_step(input int w, input int tgt, input int act, input int req,
                                    output logic boosting);
    int drv;
    int delta;
    boosting = 1'b0;
    drv = (req > DriveFullScale) ? DriveFullScale : (req < -DriveFullScale) ? -DriveFullScale : req;
    if (!tgt_live(tgt)) begin
      boost_cnt[w] = 0;
      last_target[w] = tgt;
      last_drive[w] = 0;
      return 0;
    end
    // start from rest or strict sign reversal reloads the boost counter
    if (!tgt_live(last_target[w]) || (last_target[w] > 0 && tgt < 0) ||
        (last_target[w] < 0 && tgt > 0))
      boost_cnt[w] = boost_len;
    if (((act < 0) ? -act : act) > move_thr)
      boost_cnt[w] = 0;
    last_target[w] = tgt;
    if (boost_cnt[w] != 0) begin
      boost_cnt[w]--;
      boosting = 1'b1;
    end
    if (boosting) begin
      if (boost_floor > 0) begin
        // zero target boosts in the positive direction
        if (tgt >= 0 && drv < boost_floor) drv = boost_floor;
        if (tgt < 0 && drv > -boost_floor) drv = -boost_floor;
      end
      if (drv > DriveFullScale) drv = DriveFullScale;
      else if (drv < -DriveFullScale) drv = -DriveFullScale;
    end else if (slew_max > 0) begin
      delta = drv - last_drive[w];
      if (delta > slew_max) drv = last_drive[w] + slew_max;
      else if (delta < -slew_max) drv = last_drive[w] - slew_max;
    end
    last_drive[w] = drv;
    return drv;
  endfunction

  function automatic drive_res_t predict_drives(input tick_t t);
    drive_res_t r;
    int tg[2];
    int ac[2];
    int rq[2];
    int drv[2];
    logic bst[2];
    logic hit;
    r = '0;
    hit = 1'b0;
    tg[0] = t.left_target;
    tg[1] = t.right_target;
    ac[0] = t.left_actual;
    ac[1] = t.right_actual;
    rq[0] = t.left_request;
    rq[1] = t.right_request;
    for (int i = 0; i < 2; i++) begin
      if (tg[i] > lim_speed) begin
        tg[i] = lim_speed;
        hit = 1'b1;
      end else if (tg[i] < -lim_speed) begin
        tg[i] = -lim_speed;
        hit = 1'b1;
      end
    end
    for (int i = 0; i < 2; i++) begin
      drv[i] = wheel_step(i, tg[i], ac[i], rq[i], bst[i]);
      if (drv[i] == DriveFullScale || drv[i] == -DriveFullScale) hit = 1'b1;
    end
    r.left_drive = DriveW'(drv[0]);
    r.right_drive = DriveW'(drv[1]);
    r.left_boosting = bst[0];
    r.right_boosting = bst[1];
    r.limited = hit;
    return r;
  endfunction

  function automatic void check_field(input string field, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endfunction

  // result checking, prediction on request acceptance, and the watchdog
  always @(posedge clk_i) begin
    drive_res_t got;
    drive_res_t want;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got = drive_res_t'(m_axis_tdata_o);
        if (pending_drives.size() == 0) begin
          errors++;
          $display("%0t: result with nothing expected, expected none, actual %h", $time, got);
        end else begin
          want = pending_drives.pop_front();
          check_field("left_drive", want.left_drive, got.left_drive);
          check_field("right_drive", want.right_drive, got.right_drive);
          check_field("left_boosting", want.left_boosting, got.left_boosting);
          check_field("right_boosting", want.right_boosting, got.right_boosting);
          check_field("limited", want.limited, got.limited);
          check_field("zero fill", want.fill, got.fill);
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_o)
        pending_drives.push_back(predict_drives(tick_t'(s_axis_tdata_i)));
    end
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) || cfg_we_i)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= StallLimit) begin
      $display("%0t: no progress for %0d cycles", $time, StallLimit);
      $display("[wheel_drive_slew_and_start_boost_unit] ERROR");
      $finish;
    end
  end

  // receiver back-pressure
  always @(negedge clk_i) begin
    case (rx_mode)
      RxSteady: begin
        m_axis_tready_i <= 1'b1;
      end
      RxRandom: begin
        m_axis_tready_i <= ($urandom_range(2, 0) != 0);
      end
      RxLongStall: begin
        if (rx_hold > 0) begin
          rx_hold--;
          m_axis_tready_i <= 1'b0;
        end else if ($urandom_range(9, 0) == 0) begin
          rx_hold = $urandom_range(15, 1);
          m_axis_tready_i <= 1'b0;
        end else begin
          m_axis_tready_i <= 1'b1;
        end
      end
      default: begin
        rx_phase++;
        m_axis_tready_i <= (rx_phase != 2'b11);
      end
    endcase
  end

  task automatic send_tick(input tick_t t);
    int gap;
    @(negedge clk_i);
    if (tx_gaps && burst_left == 0) begin
      gap = ($urandom_range(4, 0) == 0) ? $urandom_range(20, 5) : $urandom_range(3, 1);
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
      burst_left = $urandom_range(16, 1);
    end
    if (burst_left > 0) burst_left--;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= t;
    do @(posedge clk_i); while (!(s_axis_tvalid_i && s_axis_tready_o));
  endtask

  task automatic quiesce();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (pending_drives.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    case (idx)
      CfgSpeedLimit: lim_speed = val[14:0];
      CfgDeadband:   band = val[14:0];
      CfgMoving:     move_thr = val[14:0];
      CfgBoostLevel: boost_floor = val[9:0];
      CfgSlewStep:   slew_max = val[9:0];
      CfgBoostTicks: boost_len = val[15:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic [15:0] sl, input logic [15:0] db,
                                input logic [15:0] mv, input logic [15:0] lv,
                                input logic [15:0] sw, input logic [15:0] bt);
    quiesce();
    write_reg(CfgSpeedLimit, sl);
    write_reg(CfgDeadband, db);
    write_reg(CfgMoving, mv);
    write_reg(CfgBoostLevel, lv);
    write_reg(CfgSlewStep, sw);
    write_reg(CfgBoostTicks, bt);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic signed [15:0] sat16(input int v);
    return (v > 32767) ? 16'sh7fff : (v < -32768) ? 16'sh8000 : 16'(v);
  endfunction

  function automatic tick_t mk_tick(input int lt, input int rt, input int la, input int ra,
                                    input int lr, input int rr);
    tick_t t;
    t.left_target = 16'(lt);
    t.right_target = 16'(rt);
    t.left_actual = 16'(la);
    t.right_actual = 16'(ra);
    t.left_request = 16'(lr);
    t.right_request = 16'(rr);
    return t;
  endfunction

  function automatic int pick_target(input int prev);
    int k;
    int mag;
    k = $urandom_range(99, 0);
    if (k < 15)
      return int'($urandom_range(2 * band + 2, 0)) - band - 1;
    if (k < 30)
      return -prev;
    if (k < 40) begin
      mag = lim_speed + int'($urandom_range(500, 0));
      return $urandom_range(1, 0) ? mag : -mag;
    end
    if (k < 85)
      return prev + int'($urandom_range(200, 0)) - 100;
    return int'($urandom_range(2 * (lim_speed + band), 0)) - lim_speed - band;
  endfunction

  function automatic int pick_actual();
    if ($urandom_range(9, 0) < 6)
      return int'($urandom_range(2 * move_thr + 4, 0)) - move_thr - 2;
    return int'($urandom_range(4000, 0)) - 2000;
  endfunction

  function automatic int pick_request();
    if ($urandom_range(4, 0) != 0)
      return int'($urandom_range(2400, 0)) - 1200;
    return int'($signed(16'($urandom())));
  endfunction

  // target sequences that creep, reverse, rest and overshoot
  function automatic tick_t shaped_tick();
    tick_t t;
    int tg[2];
    for (int i = 0; i < 2; i++) begin
      tg[i] = sat16(pick_target(gen_prev[i]));
      gen_prev[i] = tg[i];
    end
    t.left_target = sat16(tg[0]);
    t.right_target = sat16(tg[1]);
    t.left_actual = sat16(pick_actual());
    t.right_actual = sat16(pick_actual());
    t.left_request = sat16(pick_request());
    t.right_request = sat16(pick_request());
    return t;
  endfunction

  task automatic run_traffic(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99, 0) < 15)
        send_tick(tick_t'({$urandom(), $urandom(), $urandom()}));
      else
        send_tick(shaped_tick());
    end
  endtask

  task automatic test_reset_settings();
    tx_gaps = 1'b1;
    rx_mode = RxRandom;
    send_tick(mk_tick(0, 0, 0, 0, 0, 0));
    send_tick(mk_tick(19, -19, 0, 0, 500, -500));
    send_tick(mk_tick(20, -20, 0, 0, 1001, -1001));
    send_tick(mk_tick(32767, -32768, 32767, -32768, 32767, -32768));
    send_tick(mk_tick(2000, -2000, -1, 1, 0, 0));
    send_tick(mk_tick(2001, -2001, 0, 0, -1000, 1000));
  endtask

  task automatic test_boost_and_slew();
    apply_settings(2000, 20, 50, 300, 50, 3);
    send_tick(mk_tick(0, 0, 0, 0, 0, 0));
    send_tick(mk_tick(500, -500, 0, 0, 100, -100));
    send_tick(mk_tick(500, -500, 0, 0, 100, -100));
    // left is already moving, right sits right at the threshold
    send_tick(mk_tick(500, -500, 60, -50, 1000, -1000));
    send_tick(mk_tick(-500, 500, 0, 0, 0, 0));
    send_tick(mk_tick(-500, 500, -51, 51, -1000, 1000));
  endtask

  task automatic test_zero_target_boost();
    // boost level above full scale, every target active
    apply_settings(2000, 0, 50, 1023, 0, 4);
    send_tick(mk_tick(500, 500, 0, 0, 0, 0));
    send_tick(mk_tick(0, 0, 0, 0, -800, 800));
    send_tick(mk_tick(-300, -300, 0, 0, 200, -200));
    send_tick(mk_tick(-300, -300, 0, 0, 200, -200));
    send_tick(mk_tick(-300, -300, 0, 0, 200, -200));
    // any motion cancels, boost without raise
    apply_settings(2000, 20, 0, 0, 1000, 2);
    send_tick(mk_tick(400, -400, 1, 0, 200, -200));
    send_tick(mk_tick(-400, 400, 0, 0, 1000, -1000));
  endtask

  task automatic test_random_traffic();
    logic [15:0] noise;
    apply_settings(2000, 20, 50, 300, 40, 5);
    tx_gaps = 1'b0;
    rx_mode = RxSteady;
    run_traffic(80);

    apply_settings(16'($urandom_range(3000, 100)), 16'($urandom_range(100, 0)),
                   16'($urandom_range(300, 0)), 16'($urandom_range(1000, 0)),
                   16'($urandom_range(300, 0)), 16'($urandom_range(8, 0)));
    tx_gaps = 1'b1;
    rx_mode = RxRandom;
    run_traffic(100);

    apply_settings(0, 0, 0, 0, 0, 0);
    rx_mode = RxLongStall;
    run_traffic(70);

    // all ones: register bits above each width must be dropped
    apply_settings(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    rx_mode = RxCadence;
    run_traffic(50);

    apply_settings(16'h7fff, 0, 16'h7fff, 1000, 1000, 16'hffff);
    rx_mode = RxRandom;
    run_traffic(60);

    for (int p = 0; p < 3; p++) begin
      noise = ($urandom_range(3, 0) == 0) ? 16'($urandom()) : '0;
      apply_settings({noise[15], 15'($urandom_range(3000, 100))},
                     {noise[14], 15'($urandom_range(100, 0))},
                     {noise[13], 15'($urandom_range(300, 0))},
                     {noise[5:0], 10'($urandom_range(1000, 0))},
                     {noise[11:6], 10'(($urandom_range(3, 0) == 0) ? 0 : $urandom_range(300, 1))},
                     16'($urandom_range(8, 0)));
      tx_gaps = 1'($urandom_range(1, 0));
      rx_mode = rx_mode_e'($urandom_range(3, 0));
      run_traffic(80);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_reset_settings();
    test_boost_and_slew();
    test_zero_target_boost();
    test_random_traffic();
    quiesce();
    if (errors == 0)
      $display("[wheel_drive_slew_and_start_boost_unit] OK");
    else
      $display("[wheel_drive_slew_and_start_boost_unit] ERROR");
    $finish;
  end

endmodule
